// ===== hw/rtl/pcck_pkg.sv =====
// Shared constants, types and status codes of the patch compositor.
package pcck_pkg;

    localparam int TEX_W_MAX     = 256;
    localparam int TEX_H_MAX     = 256;
    localparam int PATCH_DIM_MAX = 1024;

    localparam int STORE_DEPTH = TEX_W_MAX * TEX_H_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int X_W         = (TEX_W_MAX > 1) ? $clog2(TEX_W_MAX) : 1;
    localparam int Y_W         = (TEX_H_MAX > 1) ? $clog2(TEX_H_MAX) : 1;

    localparam int DIM_W   = 9;
    localparam int KEY_W   = 8;
    localparam int RGB_W   = 24;
    localparam int OFS_W   = 16;
    localparam int PCRD_W  = 10;
    localparam int RCRD_W  = 8;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [DIM_W-1:0] TEX_W_RESET = DIM_W'(256);
    localparam logic [DIM_W-1:0] TEX_H_RESET = DIM_W'(256);

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_CLIPPED = 2'd1,
        ST_KEYED   = 2'd2,
        ST_READ    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_TEX_WIDTH  = 2'd0,
        REG_TEX_HEIGHT = 2'd1,
        REG_KEY_VALUE  = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

endpackage

// ===== hw/rtl/pcck_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module pcck_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/patch_compositor_clipped_keyed.sv =====
// Top level of the clipped, colour-keyed patch compositor over a texture store.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | to block  | i_valid / o_ready  | cmd, offset_x/y, patch_col/row, pixel_rgb,
//          |           |                    | read_x, read_y
//  out     | from block| o_valid / i_ready  | status, read_rgb
//  config  | to block  | psel/penable/...   | texture_width, texture_height, key_value
//
// One item per cycle sustained while i_ready stays high and the sweep is done; o_valid
// rises once the item has moved from stage one into the output register.
// Stage one computes the target, clip and key decision and the store address
// (one 8x9 multiply); stage two performs the single store access (write or
// registered read) as the item moves into the output register.
// After reset the store is swept to zero, one entry per cycle, through all 65536 entries,
// during which o_ready stays low (configuration writes are still taken).
// A stalled output holds stage two; stage one then holds too, and outside the sweep
// input stalls only once both stages are full.
module patch_compositor_clipped_keyed
    import pcck_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,

    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_cmd,
    input  logic signed [OFS_W-1:0]  i_offset_x,
    input  logic signed [OFS_W-1:0]  i_offset_y,
    input  logic [PCRD_W-1:0]        i_patch_col,
    input  logic [PCRD_W-1:0]        i_patch_row,
    input  logic [RGB_W-1:0]         i_pixel_rgb,
    input  logic [RCRD_W-1:0]        i_read_x,
    input  logic [RCRD_W-1:0]        i_read_y,

    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_status,
    output logic [RGB_W-1:0]         o_read_rgb
);

    // Configuration registers
    logic [DIM_W-1:0] r_tex_width;
    logic [DIM_W-1:0] r_tex_height;
    logic [KEY_W-1:0] r_key_value;
    t_reg_idx         cfg_idx;
    logic             cfg_wr;

    // Store clearing sweep
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Stage one: decision and address
    logic              r_s1_valid;
    t_status           r_s1_status;
    logic              r_s1_we;
    logic              r_s1_re;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [RGB_W-1:0]  r_s1_data;

    // Stage two: output register
    logic              r_s2_valid;
    t_status           r_s2_status;
    logic              r_s2_re;

    t_status           n_s1_status;
    logic              n_s1_we;
    logic              n_s1_re;
    logic [ADDR_W-1:0] n_s1_addr;

    logic [DIM_W-1:0]      w_act;
    logic [DIM_W-1:0]      h_act;
    logic signed [OFS_W:0] tx;
    logic signed [OFS_W:0] ty;
    logic                  outside;
    logic                  keyed;
    logic                  rd_inside;
    logic [X_W-1:0]        sel_x;
    logic [Y_W-1:0]        sel_y;
    logic [Y_W+DIM_W-1:0]  row_base;

    logic              accept;
    logic              adv2;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [RGB_W-1:0]  ram_wdata;
    logic [RGB_W-1:0]  ram_rdata;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= TEX_W_RESET;
            r_tex_height <= TEX_H_RESET;
            r_key_value  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TEX_WIDTH:  r_tex_width  <= pwdata[DIM_W-1:0];
                REG_TEX_HEIGHT: r_tex_height <= pwdata[DIM_W-1:0];
                REG_KEY_VALUE:  r_key_value  <= pwdata[KEY_W-1:0];
                REG_NONE:       ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TEX_WIDTH:  prdata = APB_DW'(r_tex_width);
            REG_TEX_HEIGHT: prdata = APB_DW'(r_tex_height);
            REG_KEY_VALUE:  prdata = APB_DW'(r_key_value);
            REG_NONE:       prdata = '0;
        endcase
    end

    // ---------------- stage one: clip, key and address ----------------
    // Saturate oversized dimensions to the store's extent.
    assign w_act = (r_tex_width  > DIM_W'(TEX_W_MAX)) ? DIM_W'(TEX_W_MAX) : r_tex_width;
    assign h_act = (r_tex_height > DIM_W'(TEX_H_MAX)) ? DIM_W'(TEX_H_MAX) : r_tex_height;

    assign tx = {i_offset_x[OFS_W-1], i_offset_x}
              + $signed({{(OFS_W+1-PCRD_W){1'b0}}, i_patch_col});
    assign ty = {i_offset_y[OFS_W-1], i_offset_y}
              + $signed({{(OFS_W+1-PCRD_W){1'b0}}, i_patch_row});

    // Negative targets clip via the sign bit; otherwise compare magnitude.
    assign outside = (int'(i_patch_col) >= PATCH_DIM_MAX) || (int'(i_patch_row) >= PATCH_DIM_MAX)
                  || tx[OFS_W] || ty[OFS_W]
                  || (tx[OFS_W-1:0] >= OFS_W'(w_act))
                  || (ty[OFS_W-1:0] >= OFS_W'(h_act));
    assign keyed     = (i_pixel_rgb[RGB_W-1 -: KEY_W] == r_key_value);
    assign rd_inside = (DIM_W'(i_read_x) < w_act) && (DIM_W'(i_read_y) < h_act);

    // One shared multiplier forms row * width + column for both item kinds.
    assign sel_x    = i_cmd ? X_W'(i_read_x) : tx[X_W-1:0];
    assign sel_y    = i_cmd ? Y_W'(i_read_y) : ty[Y_W-1:0];
    assign row_base = sel_y * w_act;

    always_comb begin
        n_s1_addr = ADDR_W'(row_base) + ADDR_W'(sel_x);
        n_s1_we   = 1'b0;
        n_s1_re   = 1'b0;
        priority if (i_cmd) begin
            n_s1_status = ST_READ;
            n_s1_re     = rd_inside;
        end else if (outside) begin
            n_s1_status = ST_CLIPPED;
        end else if (keyed) begin
            n_s1_status = ST_KEYED;
        end else begin
            n_s1_status = ST_STORED;
            n_s1_we     = 1'b1;
        end
    end

    // ---------------- handshakes ----------------
    assign adv2    = r_s1_valid && (!r_s2_valid || i_ready);
    assign o_ready = !r_clr_busy && (!r_s1_valid || adv2);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv2) begin
                r_s1_valid <= 1'b0;
            end
            if (adv2) begin
                r_s2_valid <= 1'b1;
            end else if (i_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_s1_status;
            r_s1_we     <= n_s1_we;
            r_s1_re     <= n_s1_re;
            r_s1_addr   <= n_s1_addr;
            r_s1_data   <= i_pixel_rgb;
        end
        if (adv2) begin
            r_s2_status <= r_s1_status;
            r_s2_re     <= r_s1_re;
        end
    end

    // ---------------- clearing sweep ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- texture store ----------------
    // Each item makes its single access as it enters the output register, so
    // a write always lands before any later item's read: no forwarding needed.
    assign ram_we    = r_clr_busy || (adv2 && r_s1_we);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : r_s1_data;

    pcck_ram #(
        .WIDTH (RGB_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv2 && r_s1_re),
        .i_raddr (r_s1_addr),
        .o_rdata (ram_rdata)
    );

    // Read data stays put until the next item enters stage two.
    assign o_valid    = r_s2_valid;
    assign o_status   = r_s2_status;
    assign o_read_rgb = r_s2_re ? ram_rdata : '0;

endmodule

// ===== hw/rtl/pcck_checker.sv =====
// Port-level checker for the patch compositor, bound to the top level.
module pcck_checker
    import pcck_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [1:0]              o_status,
    input logic [RGB_W-1:0]        o_read_rgb
);

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_read_rgb))
        else $error("result changed while stalled");

    // Only read items carry pixel data.
    a_rgb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_READ) |-> o_read_rgb == '0)
        else $error("write item carries non-zero read_rgb");

    // Reset empties the pipeline and starts the store sweep.
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("block not idle after reset");

    // No result can appear without an accepted item having passed through stage one.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid ##1 o_valid |-> $past(i_valid && o_ready, 2))
        else $error("result without an accepted item");

endmodule

bind patch_compositor_clipped_keyed pcck_checker u_pcck_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_status   (o_status),
    .o_read_rgb (o_read_rgb)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the clipped, colour-keyed patch compositor.
`timescale 1ns / 100ps

module tb_top;
    import pcck_pkg::*;

    localparam logic CMD_COMPOSITE = 1'b0;
    localparam logic CMD_READ      = 1'b1;

    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 145;

    // One input item as it travels over the pixel channel.
    typedef struct packed {
        logic                    cmd;
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
        logic [PCRD_W-1:0]       patch_col;
        logic [PCRD_W-1:0]       patch_row;
        logic [RGB_W-1:0]        pixel_rgb;
        logic [RCRD_W-1:0]       read_x;
        logic [RCRD_W-1:0]       read_y;
    } t_pixel_item;

    typedef struct packed {
        t_status          status;
        logic [RGB_W-1:0] rgb;
    } t_pixel_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_cmd = 1'b0;
    logic signed [OFS_W-1:0] i_offset_x = '0;
    logic signed [OFS_W-1:0] i_offset_y = '0;
    logic [PCRD_W-1:0]       i_patch_col = '0;
    logic [PCRD_W-1:0]       i_patch_row = '0;
    logic [RGB_W-1:0]        i_pixel_rgb = '0;
    logic [RCRD_W-1:0]       i_read_x = '0;
    logic [RCRD_W-1:0]       i_read_y = '0;

    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [1:0]       o_status;
    logic [RGB_W-1:0] o_read_rgb;

    patch_compositor_clipped_keyed u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_offset_x  (i_offset_x),
        .i_offset_y  (i_offset_y),
        .i_patch_col (i_patch_col),
        .i_patch_row (i_patch_row),
        .i_pixel_rgb (i_pixel_rgb),
        .i_read_x    (i_read_x),
        .i_read_y    (i_read_y),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_read_rgb  (o_read_rgb)
    );

    // 10 ns clock: rising edges on odd multiples of 5 ns.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the texture.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] tex_width_q  = TEX_W_RESET;
    logic [DIM_W-1:0] tex_height_q = TEX_H_RESET;
    logic [KEY_W-1:0] key_q        = '0;
    logic [RGB_W-1:0] texture_store [STORE_DEPTH];

    t_pixel_item   pixel_feed[$];        // items waiting for the driver
    t_pixel_result pending_results[$];   // expected results, oldest first
    logic [15:0]   recent_spots[$];      // {y, x} of pixels stored this phase

    int unsigned offered = 0;      // items put on the bus by the driver
    int unsigned taken = 0;        // items accepted by the block
    int unsigned error_count = 0;

    // Saturate the width/height registers to the store's geometry.
    function automatic int active_width();
        return (tex_width_q > TEX_W_MAX) ? TEX_W_MAX : int'(tex_width_q);
    endfunction

    function automatic int active_height();
        return (tex_height_q > TEX_H_MAX) ? TEX_H_MAX : int'(tex_height_q);
    endfunction

    // Work out the result of one accepted item and update the texture copy.
    // Clipping is decided before the key test, so a keyed pixel outside the
    // texture still reports as clipped.
    function automatic t_pixel_result composite_pixel(input t_pixel_item px);
        t_pixel_result r;
        int w;
        int h;
        int tx;
        int ty;
        w = active_width();
        h = active_height();
        r.rgb = '0;
        if (px.cmd == CMD_READ) begin
            r.status = ST_READ;
            if (int'(px.read_x) < w && int'(px.read_y) < h)
                r.rgb = texture_store[int'(px.read_y) * w + int'(px.read_x)];
        end else begin
            tx = int'($signed(px.offset_x)) + int'(px.patch_col);
            ty = int'($signed(px.offset_y)) + int'(px.patch_row);
            if (px.patch_col >= PATCH_DIM_MAX || px.patch_row >= PATCH_DIM_MAX ||
                tx < 0 || ty < 0 || tx >= w || ty >= h) begin
                r.status = ST_CLIPPED;
            end else if (px.pixel_rgb[23:16] == key_q) begin
                r.status = ST_KEYED;
            end else begin
                r.status = ST_STORED;
                texture_store[ty * w + tx] = px.pixel_rgb;
            end
        end
        return r;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present items from the feed in bursts with random gaps.
    // Hold an item until the block takes it; advance on the next falling
    // edge after acceptance.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin
        t_pixel_item it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && taken != offered) begin
            // hold: item still waiting for o_ready
        end else if (gap_left != 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (pixel_feed.size() == 0) begin
            i_valid <= 1'b0;
        end else begin
            it = pixel_feed.pop_front();
            i_cmd       <= it.cmd;
            i_offset_x  <= it.offset_x;
            i_offset_y  <= it.offset_y;
            i_patch_col <= it.patch_col;
            i_patch_row <= it.patch_row;
            i_pixel_rgb <= it.pixel_rgb;
            i_read_x    <= it.read_x;
            i_read_y    <= it.read_y;
            i_valid     <= 1'b1;
            offered++;
            if (burst_left != 0) begin
                burst_left--;
            end else begin
                // End of burst: some bursts run straight into the next one.
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a random stall mode, redrawn whenever its run ends, plus long
    // hold-offs so that both pipeline stages fill and o_ready drops. The
    // first long hold is forced once traffic is flowing.
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned rx_mode = 0;
    bit          first_hold_done = 1'b0;
    logic [7:0]  stall_pat = 8'hA5;

    always @(negedge i_clk) begin
        logic ready_next;
        if (mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
            stall_pat = 8'($urandom);
            if (first_hold_done && $urandom_range(0, 9) == 0)
                hold_left = $urandom_range(40, 120);
        end
        mode_left--;
        if (!first_hold_done && taken > 300 && pixel_feed.size() > 20) begin
            first_hold_done = 1'b1;
            hold_left = 150;
        end
        if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            case (rx_mode)
                0: ready_next = 1'b1;
                1: ready_next = 1'($urandom_range(0, 1));
                2: begin
                    ready_next = stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[7:1]};
                end
                default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
        end
        i_ready <= ready_next;
    end

    // ------------------------------------------------------------------
    // Monitor: check results against the oldest expectation, then predict
    // for the item accepted at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel_item   seen;
        t_pixel_result want;
        t_pixel_result predicted;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    note_error($sformatf("result with nothing expected: status %0d rgb %06h",
                                         o_status, o_read_rgb));
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status || o_read_rgb !== want.rgb)
                        note_error($sformatf(
                            "expected status %0d rgb %06h, got status %0d rgb %06h",
                            want.status, want.rgb, o_status, o_read_rgb));
                end
            end
            if (i_valid && o_ready) begin
                seen.cmd       = i_cmd;
                seen.offset_x  = i_offset_x;
                seen.offset_y  = i_offset_y;
                seen.patch_col = i_patch_col;
                seen.patch_row = i_patch_row;
                seen.pixel_rgb = i_pixel_rgb;
                seen.read_x    = i_read_x;
                seen.read_y    = i_read_y;
                predicted = composite_pixel(seen);
                pending_results.insert(pending_results.size(), predicted);
                taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic cmd, input int ox, input int oy, input int pc,
                             input int pr, input logic [RGB_W-1:0] rgb,
                             input int rx, input int ry);
        t_pixel_item it;
        it.cmd       = cmd;
        it.offset_x  = OFS_W'(ox);
        it.offset_y  = OFS_W'(oy);
        it.patch_col = PCRD_W'(pc);
        it.patch_row = PCRD_W'(pr);
        it.pixel_rgb = rgb;
        it.read_x    = RCRD_W'(rx);
        it.read_y    = RCRD_W'(ry);
        pixel_feed.insert(pixel_feed.size(), it);
    endtask

    // APB write: setup, then access; the register lands when pready is seen.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TEX_WIDTH:  tex_width_q  = value[DIM_W-1:0];
            REG_TEX_HEIGHT: tex_height_q = value[DIM_W-1:0];
            REG_KEY_VALUE:  key_q        = value[KEY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait for the feed to empty and every result to arrive, then let the
    // two-stage pipeline settle.
    task automatic wait_until_idle();
        while (pixel_feed.size() != 0 || offered != taken || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-formed composites aimed at (or just around) the active
    // area, read-backs of pixels stored this phase, and some raw noise.
    task automatic queue_random_items(input int count);
        int w;
        int h;
        int tx;
        int ty;
        int pc;
        int pr;
        int ox;
        int oy;
        int rx;
        int ry;
        int pick;
        bit aimed;
        logic [RGB_W-1:0] rgb;
        logic [15:0] spot;
        w = active_width();
        h = active_height();
        recent_spots.delete();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            rgb = RGB_W'($urandom);
            if (pick < 8) begin
                push_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                          rgb, $urandom, $urandom);
            end else if (pick < 38) begin
                if (recent_spots.size() != 0 && $urandom_range(0, 1) == 1) begin
                    spot = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
                    rx = int'(spot[7:0]);
                    ry = int'(spot[15:8]);
                end else if (w > 0 && h > 0 && $urandom_range(0, 3) != 0) begin
                    rx = $urandom_range(0, w - 1);
                    ry = $urandom_range(0, h - 1);
                end else begin
                    rx = $urandom_range(0, 255);
                    ry = $urandom_range(0, 255);
                end
                push_item(CMD_READ, $urandom, $urandom, $urandom, $urandom, rgb, rx, ry);
            end else begin
                // Pick the target first, then split it into offset plus local
                // coordinate so that negative offsets land inside too.
                tx = int'($urandom_range(0, w + 3)) - 2;
                ty = int'($urandom_range(0, h + 3)) - 2;
                pc = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 15);
                pr = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 15);
                ox = tx - pc;
                oy = ty - pr;
                aimed = 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    ox = ox + int'($urandom_range(0, 65535)) - 32768;
                    aimed = 1'b0;
                end
                if ($urandom_range(0, 6) == 0)
                    rgb[23:16] = key_q;
                if (aimed && tx >= 0 && ty >= 0 && tx < w && ty < h &&
                    rgb[23:16] != key_q) begin
                    spot = {8'(ty), 8'(tx)};
                    recent_spots.insert(recent_spots.size(), spot);
                    if (recent_spots.size() > 48)
                        void'(recent_spots.pop_front());
                end
                push_item(CMD_COMPOSITE, ox, oy, pc, pr, rgb, $urandom, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int phase_w[PHASES] = '{16, 1, 256, 511, 0, 37, 256, 8, 300, 255, 64, 3};
    int phase_h[PHASES] = '{16, 1, 256, 300, 20, 0, 1, 8, 511, 2, 64, 256};

    initial begin
        logic [KEY_W-1:0] key;
        foreach (texture_store[a])
            texture_store[a] = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed part under the reset geometry (256 x 256, key 0).
        // The block sweeps its store after reset; o_ready holds items off.
        push_item(CMD_COMPOSITE, 0, 0, 0, 0, 24'hFFFFFF, 255, 255);          // corner
        push_item(CMD_READ, -32768, 32767, 1023, 1023, 24'hFFFFFF, 0, 0);
        push_item(CMD_COMPOSITE, 255, 255, 0, 0, 24'h123456, 0, 0);          // far corner
        push_item(CMD_READ, 0, 0, 0, 0, 24'h000000, 255, 255);
        push_item(CMD_COMPOSITE, -32768, 0, 1023, 0, 24'hA5A5A5, 0, 0);      // far left
        push_item(CMD_COMPOSITE, 32767, 32767, 1023, 1023, 24'h5A5A5A, 0, 0);
        push_item(CMD_COMPOSITE, 0, -1, 0, 0, 24'h808080, 0, 0);             // one row above
        push_item(CMD_COMPOSITE, 10, 10, 0, 0, 24'h00ABCD, 0, 0);            // keyed, inside
        push_item(CMD_COMPOSITE, -3, 0, 0, 0, 24'h00FFFF, 0, 0);             // keyed, outside
        push_item(CMD_COMPOSITE, -1023, -5, 1023, 10, 24'h800001, 0, 0);     // negative offsets
        push_item(CMD_READ, 0, 0, 0, 0, 24'h0, 0, 5);
        push_item(CMD_COMPOSITE, 200, 0, 56, 0, 24'h111111, 0, 0);           // x just past edge
        push_item(CMD_COMPOSITE, 0, 255, 0, 1, 24'h222222, 0, 0);            // y just past edge
        push_item(CMD_READ, 0, 0, 0, 0, 24'h0, 10, 10);                      // never written
        push_item(CMD_COMPOSITE, -800, -800, 1023, 1023, 24'h5A5A5A, 0, 0);
        push_item(CMD_READ, 0, 0, 0, 0, 24'h0, 223, 223);
        push_item(CMD_COMPOSITE, 0, 0, 0, 0, 24'h010203, 0, 0);              // overwrite
        push_item(CMD_READ, 0, 0, 0, 0, 24'h0, 0, 0);
        wait_until_idle();

        // Random phases: reconfigure only while the block is idle. The list
        // covers zero, one, full and oversized dimensions.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1:       key = 8'hFF;
                3:       key = 8'h00;
                default: key = KEY_W'($urandom);
            endcase
            write_reg(REG_TEX_WIDTH, APB_DW'(phase_w[p]));
            write_reg(REG_TEX_HEIGHT, APB_DW'(phase_h[p]));
            write_reg(REG_KEY_VALUE, APB_DW'(key));
            queue_random_items(ITEMS_PER_PHASE);
            wait_until_idle();
        end

        if (pending_results.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit: the post-reset sweep plus all items under the slowest
    // stall patterns fits several times over.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
